[design/srxc_pkg.sv]
// ----------------------------------------------------------------------------
// srxc_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
package srxc_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;
    localparam logic [BYTE_W-1:0] FORMAT_MARK_RST = 8'h80;
    localparam logic [BYTE_W-1:0] END_MARK_RST    = 8'h04;

    localparam logic [ADDR_W-1:0] REG_SYNC_FIRST  = 8'd0;
    localparam logic [ADDR_W-1:0] REG_SYNC_SECOND = 8'd1;
    localparam logic [ADDR_W-1:0] REG_FORMAT_MARK = 8'd2;
    localparam logic [ADDR_W-1:0] REG_END_MARK    = 8'd3;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_FORMAT  = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_END     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_ACCEPT    = 2'd1,
        KIND_CHECK_BAD = 2'd2,
        KIND_END_BAD   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] format_mark;
        logic [BYTE_W-1:0] end_mark;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] frame_length;
        logic              last_payload;
    } result_t;

endpackage

[design/serial_frame_receiver_xor_check.sv]
// ----------------------------------------------------------------------------
// serial_frame_receiver_xor_check
// Sync/length deframer with XOR checksum and terminator check.
// ----------------------------------------------------------------------------
// One received byte per input transaction, one byte per clock while s_ready
// is high. The frame state machine updates in the cycle a byte is taken and
// its result (a payload byte, or a verdict after the checksum or terminator)
// is registered toward the m_ channel through a result register backed by a
// skid stage, so s_ready only drops after m_ready has been low with two
// results held. Header mismatches restart the hunt silently; checksum match
// gives no result and the terminator byte decides accept or reject. Config
// writes (cfg_addr 0..3: sync_first, sync_second, format_mark, end_mark)
// take effect from the next byte on; other addresses are ignored.
module serial_frame_receiver_xor_check
    import srxc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [BYTE_W-1:0] m_payload_byte,
    output logic [BYTE_W-1:0] m_byte_index,
    output logic [BYTE_W-1:0] m_frame_length,
    output logic              m_last_payload
);

    cfg_t    cfg;
    logic    byte_en;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign byte_en = s_valid && s_ready;

    srxc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    srxc_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (byte_en),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    srxc_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_kind         = out_data.kind;
    assign m_payload_byte = out_data.payload_byte;
    assign m_byte_index   = out_data.byte_index;
    assign m_frame_length = out_data.frame_length;
    assign m_last_payload = out_data.last_payload;

    // skid stage only fills behind a held result
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("skid stage full with no result held");

    a_verdict_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_PAYLOAD) |->
            (m_payload_byte == '0 && m_byte_index == '0 && !m_last_payload))
        else $error("verdict carries payload fields");

    a_index_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_PAYLOAD) |-> (m_byte_index < m_frame_length))
        else $error("payload index beyond declared length");

    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_payload) |->
            (({1'b0, m_byte_index} + 9'd1) == {1'b0, m_frame_length}))
        else $error("last flag not on final payload byte");

endmodule

[design/srxc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// srxc_cfg_regs
// Configuration register bank: sync, format and terminator bytes.
// ----------------------------------------------------------------------------
module srxc_cfg_regs
    import srxc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [BYTE_W-1:0] cfg_wdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_SYNC_FIRST:  cfg_next.sync_first  = cfg_wdata;
                REG_SYNC_SECOND: cfg_next.sync_second = cfg_wdata;
                REG_FORMAT_MARK: cfg_next.format_mark = cfg_wdata;
                REG_END_MARK:    cfg_next.end_mark    = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.format_mark <= FORMAT_MARK_RST;
            cfg_reg.end_mark    <= END_MARK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/srxc_deframer.sv]
// ----------------------------------------------------------------------------
// srxc_deframer
// Frame state machine: header hunt, length, payload with running XOR,
// checksum and terminator check. One byte per accepted transaction.
// ----------------------------------------------------------------------------
module srxc_deframer
    import srxc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_en,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output logic              res_valid,
    output result_t           res
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] len_reg,   len_next;
    logic [BYTE_W-1:0] xor_reg,   xor_next;

    logic in_payload;
    logic is_last;

    assign in_payload = (count_reg < len_reg);
    assign is_last    = ({1'b0, count_reg} + 9'd1) == {1'b0, len_reg};

    // next state
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        unique case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == cfg.sync_first) phase_next = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (rx_byte == cfg.sync_second) begin
                    phase_next = PH_FORMAT;
                end else begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    len_next   = '0;
                    xor_next   = '0;
                end
            end
            PH_FORMAT: begin
                if (rx_byte == cfg.format_mark) begin
                    phase_next = PH_LENGTH;
                end else begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    len_next   = '0;
                    xor_next   = '0;
                end
            end
            PH_LENGTH: begin
                len_next   = rx_byte;
                count_next = '0;
                xor_next   = '0;
                phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (in_payload) begin
                    xor_next   = xor_reg ^ rx_byte;
                    count_next = count_reg + 8'd1;
                end else if (rx_byte == xor_reg) begin
                    phase_next = PH_END;
                end else begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    len_next   = '0;
                    xor_next   = '0;
                end
            end
            default: begin
                // terminator byte, and any stray code: back to the hunt
                phase_next = PH_HUNT;
                count_next = '0;
                len_next   = '0;
                xor_next   = '0;
            end
        endcase
    end

    // outputs
    always_comb begin
        res_valid        = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = '0;
        res.byte_index   = '0;
        res.frame_length = len_reg;
        res.last_payload = 1'b0;
        unique case (phase_reg)
            PH_PAYLOAD: begin
                if (in_payload) begin
                    res_valid        = byte_en;
                    res.payload_byte = rx_byte;
                    res.byte_index   = count_reg;
                    res.last_payload = is_last;
                end else if (rx_byte != xor_reg) begin
                    res_valid = byte_en;
                    res.kind  = KIND_CHECK_BAD;
                end
            end
            PH_END: begin
                res_valid = byte_en;
                res.kind  = (rx_byte == cfg.end_mark) ? KIND_ACCEPT : KIND_END_BAD;
            end
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            len_reg   <= '0;
            xor_reg   <= '0;
        end else if (byte_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

[design/srxc_out_buf.sv]
// ----------------------------------------------------------------------------
// srxc_out_buf
// Result register with a skid stage; ready toward the input is registered.
// ----------------------------------------------------------------------------
module srxc_out_buf
    import srxc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg,  main_data_next;
    result_t skid_data_reg,  skid_data_next;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                // no push can arrive while the skid stage is full
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign room      = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule
